FILE: hdl/psp_pkg.sv
// Types and constants for the point to segment projection block.
`timescale 1ns / 1ps
`default_nettype none
package psp_pkg;
    localparam int COORD_BITS      = 24;
    localparam int T_FRAC_BITS_DEF = 16;
    localparam int DIST_BITS       = 50;
    localparam int DIFF_BITS       = COORD_BITS + 1;
    localparam int SQ_BITS         = 2 * DIFF_BITS;
    localparam int L2_BITS         = SQ_BITS;
    localparam int DOT_BITS        = SQ_BITS + 1;

    typedef logic [1:0] t_case;
    localparam t_case CASE_INTERIOR = 2'd0;
    localparam t_case CASE_BEFORE   = 2'd1;
    localparam t_case CASE_BEYOND   = 2'd2;
    localparam t_case CASE_ZERO     = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_end;
    } t_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] nearest_x;
        logic signed [COORD_BITS-1:0] nearest_y;
        t_case                        case_code;
        logic [DIST_BITS-1:0]         dist_sqr;
    } t_out;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] px;
        logic signed [COORD_BITS-1:0] py;
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by_end;
        logic signed [DIFF_BITS-1:0]  dx;
        logic signed [DIFF_BITS-1:0]  dy;
    } t_geo;
endpackage
`default_nettype wire

FILE: hdl/point_segment_projection.sv
// Point to segment projection: nearest point, case code and squared distance.
// Fully pipelined: one point/segment pair per cycle while not stalled. t comes
// from a restoring divider, which resolves one quotient bit per stage. Stall
// freezes the whole pipeline; a transfer into the block happens whenever
// o_stall is low and i_valid high.
`timescale 1ns / 1ps
`default_nettype none
module point_segment_projection
    import psp_pkg::*;
#(
    parameter int T_FRAC_BITS = T_FRAC_BITS_DEF
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_stall,
    input  wire t_in i_data,
    output logic o_valid,
    input  wire  i_stall,
    output t_out o_data
);
    localparam int TW = T_FRAC_BITS + 1;
    localparam int PW = DIFF_BITS + TW + 1;

    logic en;
    logic r_out_v;
    t_out r_out;

    assign en      = !r_out_v || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

    // differences
    logic r_s1_v;
    t_geo r_s1_g;
    logic signed [DIFF_BITS-1:0] r_s1_ux, r_s1_uy;
    // products
    logic r_s2_v;
    t_geo r_s2_g;
    logic signed [SQ_BITS-1:0] r_s2_xx, r_s2_yy, r_s2_ux, r_s2_uy;
    // sums
    logic r_s3_v;
    t_geo r_s3_g;
    logic [L2_BITS-1:0] r_s3_l2;
    logic signed [DOT_BITS-1:0] r_s3_dot;
    // case
    logic r_s4_v;
    t_geo r_s4_g;
    t_case r_s4_code;
    logic [L2_BITS-1:0] r_s4_num, r_s4_den;
    // divider
    logic               r_dv_v    [0:T_FRAC_BITS];
    t_geo               r_dv_g    [0:T_FRAC_BITS];
    t_case              r_dv_code [0:T_FRAC_BITS];
    logic [L2_BITS-1:0] r_dv_rem  [0:T_FRAC_BITS];
    logic [L2_BITS-1:0] r_dv_den  [0:T_FRAC_BITS];
    logic [TW-1:0]      r_dv_q    [0:T_FRAC_BITS];
    // interpolation
    logic r_l1_v;
    t_geo r_l1_g;
    t_case r_l1_code;
    logic signed [PW-1:0] r_l1_mx, r_l1_my;
    logic r_l2_v;
    logic signed [COORD_BITS-1:0] r_l2_px, r_l2_py, r_l2_nx, r_l2_ny;
    t_case r_l2_code;
    // distance
    logic r_e1_v;
    logic signed [COORD_BITS-1:0] r_e1_nx, r_e1_ny;
    t_case r_e1_code;
    logic signed [DIFF_BITS-1:0] r_e1_ex, r_e1_ey;
    logic r_e2_v;
    logic signed [COORD_BITS-1:0] r_e2_nx, r_e2_ny;
    t_case r_e2_code;
    logic signed [SQ_BITS-1:0] r_e2_xx, r_e2_yy;

    t_geo n_s1_g;
    t_case n_s4_code;
    logic signed [PW-1:0] n_l2_sx, n_l2_sy;

    always_comb begin
        n_s1_g.px     = i_data.px;
        n_s1_g.py     = i_data.py;
        n_s1_g.ax     = i_data.ax;
        n_s1_g.ay     = i_data.ay;
        n_s1_g.bx     = i_data.bx;
        n_s1_g.by_end = i_data.by_end;
        n_s1_g.dx     = DIFF_BITS'(i_data.bx) - DIFF_BITS'(i_data.ax);
        n_s1_g.dy     = DIFF_BITS'(i_data.by_end) - DIFF_BITS'(i_data.ay);
    end

    always_comb begin
        if (r_s3_l2 == '0) begin
            n_s4_code = CASE_ZERO;
        end else if (r_s3_dot[DOT_BITS-1]) begin
            n_s4_code = CASE_BEFORE;
        end else if (r_s3_dot > $signed({1'b0, r_s3_l2})) begin
            n_s4_code = CASE_BEYOND;
        end else begin
            n_s4_code = CASE_INTERIOR;
        end
    end

    assign n_l2_sx = r_l1_mx >>> T_FRAC_BITS;
    assign n_l2_sy = r_l1_my >>> T_FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_l1_v  <= 1'b0;
            r_l2_v  <= 1'b0;
            r_e1_v  <= 1'b0;
            r_e2_v  <= 1'b0;
            r_out_v <= 1'b0;
        end else if (en) begin
            r_s1_v  <= i_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_l1_v  <= r_dv_v[T_FRAC_BITS];
            r_l2_v  <= r_l1_v;
            r_e1_v  <= r_l2_v;
            r_e2_v  <= r_e1_v;
            r_out_v <= r_e2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_g  <= n_s1_g;
            r_s1_ux <= DIFF_BITS'(i_data.px) - DIFF_BITS'(i_data.ax);
            r_s1_uy <= DIFF_BITS'(i_data.py) - DIFF_BITS'(i_data.ay);

            r_s2_g  <= r_s1_g;
            r_s2_xx <= r_s1_g.dx * r_s1_g.dx;
            r_s2_yy <= r_s1_g.dy * r_s1_g.dy;
            r_s2_ux <= r_s1_ux * r_s1_g.dx;
            r_s2_uy <= r_s1_uy * r_s1_g.dy;

            r_s3_g   <= r_s2_g;
            r_s3_l2  <= L2_BITS'(unsigned'(r_s2_xx)) + L2_BITS'(unsigned'(r_s2_yy));
            r_s3_dot <= DOT_BITS'(r_s2_ux) + DOT_BITS'(r_s2_uy);

            r_s4_g    <= r_s3_g;
            r_s4_code <= n_s4_code;
            r_s4_num  <= (n_s4_code == CASE_INTERIOR) ? r_s3_dot[L2_BITS-1:0] : '0;
            r_s4_den  <= (n_s4_code == CASE_INTERIOR) ? r_s3_l2 : L2_BITS'(1);

            r_l1_g    <= r_dv_g[T_FRAC_BITS];
            r_l1_code <= r_dv_code[T_FRAC_BITS];
            r_l1_mx   <= PW'(r_dv_g[T_FRAC_BITS].dx) * $signed({2'b00, r_dv_q[T_FRAC_BITS]});
            r_l1_my   <= PW'(r_dv_g[T_FRAC_BITS].dy) * $signed({2'b00, r_dv_q[T_FRAC_BITS]});

            r_l2_px   <= r_l1_g.px;
            r_l2_py   <= r_l1_g.py;
            r_l2_code <= r_l1_code;
            case (r_l1_code)
                CASE_INTERIOR: begin
                    r_l2_nx <= r_l1_g.ax + COORD_BITS'(n_l2_sx);
                    r_l2_ny <= r_l1_g.ay + COORD_BITS'(n_l2_sy);
                end
                CASE_BEYOND: begin
                    r_l2_nx <= r_l1_g.bx;
                    r_l2_ny <= r_l1_g.by_end;
                end
                default: begin
                    r_l2_nx <= r_l1_g.ax;
                    r_l2_ny <= r_l1_g.ay;
                end
            endcase

            r_e1_nx   <= r_l2_nx;
            r_e1_ny   <= r_l2_ny;
            r_e1_code <= r_l2_code;
            r_e1_ex   <= DIFF_BITS'(r_l2_px) - DIFF_BITS'(r_l2_nx);
            r_e1_ey   <= DIFF_BITS'(r_l2_py) - DIFF_BITS'(r_l2_ny);

            r_e2_nx   <= r_e1_nx;
            r_e2_ny   <= r_e1_ny;
            r_e2_code <= r_e1_code;
            r_e2_xx   <= r_e1_ex * r_e1_ex;
            r_e2_yy   <= r_e1_ey * r_e1_ey;

            r_out.nearest_x <= r_e2_nx;
            r_out.nearest_y <= r_e2_ny;
            r_out.case_code <= r_e2_code;
            r_out.dist_sqr  <= DIST_BITS'(unsigned'(r_e2_xx)) + DIST_BITS'(unsigned'(r_e2_yy));
        end
    end

    // divider, integer bit first, then one fraction bit per stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_v[0] <= 1'b0;
        end else if (en) begin
            r_dv_v[0] <= r_s4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dv_g[0]    <= r_s4_g;
            r_dv_code[0] <= r_s4_code;
            r_dv_den[0]  <= r_s4_den;
            if (r_s4_num >= r_s4_den) begin
                r_dv_rem[0] <= r_s4_num - r_s4_den;
                r_dv_q[0]   <= TW'(1);
            end else begin
                r_dv_rem[0] <= r_s4_num;
                r_dv_q[0]   <= '0;
            end
        end
    end

    for (genvar k = 1; k <= T_FRAC_BITS; k++) begin : g_div
        logic [L2_BITS:0] n_rem2;
        assign n_rem2 = {r_dv_rem[k-1], 1'b0};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[k] <= 1'b0;
            end else if (en) begin
                r_dv_v[k] <= r_dv_v[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dv_g[k]    <= r_dv_g[k-1];
                r_dv_code[k] <= r_dv_code[k-1];
                r_dv_den[k]  <= r_dv_den[k-1];
                if (n_rem2 >= {1'b0, r_dv_den[k-1]}) begin
                    r_dv_rem[k] <= L2_BITS'(n_rem2 - {1'b0, r_dv_den[k-1]});
                    r_dv_q[k]   <= {r_dv_q[k-1][TW-2:0], 1'b1};
                end else begin
                    r_dv_rem[k] <= n_rem2[L2_BITS-1:0];
                    r_dv_q[k]   <= {r_dv_q[k-1][TW-2:0], 1'b0};
                end
            end
        end
    end
endmodule
`default_nettype wire
